/* design/aec_pkg.sv */
package aec_pkg;

	// configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// result run length field
	localparam int RUN_W = 32;

	// coefficient operand of the shared multiplier: unsigned Q0.16 up to one, plus sign
	localparam int COEF_W = 18;
	localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(65536);

	// bias-corrected ewma magnitude, Q.16, only needed up to the top weight step
	localparam int Y_W = 19;
	localparam int STEPS = 6;

	// register reset values
	localparam logic [15:0] SMOOTHING_RST = 16'd6554;
	localparam logic [14:0] LIMIT_RST = 15'd3072;
	localparam logic TWO_SIDED_RST = 1'b1;

	// register map, one word each
	typedef enum logic [1:0] {
		REG_SMOOTHING = 2'd0,
		REG_LIMIT     = 2'd1,
		REG_TWO_SIDED = 2'd2
	} aec_reg_t;

	typedef struct packed {
		logic [15:0] smoothing;
		logic [14:0] limit;
		logic        two_sided;
	} aec_cfg_t;

	// weight step table: upper bound of y in Q.16 and weight in Q0.16
	localparam logic [Y_W-1:0] STEP_BOUND [STEPS] = '{
		Y_W'(16384), Y_W'(49152), Y_W'(65536),
		Y_W'(98304), Y_W'(163840), Y_W'(229376)
	};
	localparam logic [COEF_W-1:0] STEP_WEIGHT [STEPS] = '{
		COEF_W'(983), COEF_W'(6554), COEF_W'(13107),
		COEF_W'(16384), COEF_W'(32768), COEF_W'(52429)
	};

	// weight for a corrected magnitude y
	function automatic logic [COEF_W-1:0] aec_weight(input logic [Y_W-1:0] y);
		logic [COEF_W-1:0] w;
		int i;
		w = ONE_Q16;
		for (i = STEPS - 1; i >= 0; i--) begin
			if (y <= STEP_BOUND[i]) begin
				w = STEP_WEIGHT[i];
			end
		end
		if (y == '0) begin
			w = '0;
		end
		return w;
	endfunction

endpackage

/* design/aec_mul.sv */
module aec_mul #(
	parameter int A_W = 18,
	parameter int B_W = 33
) (
	input  logic                       clk,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  prod_q
);

	// shared signed multiplier with registered product
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

/* design/aec_cfg.sv */
module aec_cfg
	import aec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output aec_cfg_t          cfg
);

	aec_cfg_t cfg_q;
	aec_reg_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = aec_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing <= SMOOTHING_RST;
			cfg_q.limit     <= LIMIT_RST;
			cfg_q.two_sided <= TWO_SIDED_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SMOOTHING: begin
					cfg_q.smoothing <= pwdata[15:0];
				end
				REG_LIMIT: begin
					cfg_q.limit <= pwdata[14:0];
				end
				REG_TWO_SIDED: begin
					cfg_q.two_sided <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_SMOOTHING: prdata = DATA_W'(cfg_q.smoothing);
			REG_LIMIT:     prdata = DATA_W'(cfg_q.limit);
			REG_TWO_SIDED: prdata = DATA_W'(cfg_q.two_sided);
			default:       prdata = '0;
		endcase
	end

endmodule

/* design/aec_core.sv */
module aec_core
	import aec_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aec_cfg_t                cfg,
	input  logic                    s_valid,
	output logic                    s_ready,
	input  logic [SAMPLE_WIDTH-1:0] s_sample,
	output logic                    m_valid,
	input  logic                    m_ready,
	output logic [SAMPLE_WIDTH-1:0] m_statistic,
	output logic                    m_alarm,
	output logic [RUN_W-1:0]        m_run_length
);

	// value widths: Q.16 state, multiplier operand, product and sum
	localparam int CW        = SAMPLE_WIDTH + 6;
	localparam int BW        = (CW > 33) ? CW : 33;
	localparam int PW        = COEF_W + BW;
	localparam int SW        = PW + 1;
	localparam int MW        = (CW > Y_W) ? CW : Y_W;
	localparam int XW        = ((CW > 21) ? CW : 21) + 1;
	localparam int CXW       = (COUNT_WIDTH > RUN_W) ? COUNT_WIDTH : RUN_W;
	localparam int STEP_W    = $clog2(Y_W);
	localparam int PRE_SHIFT = 31 - Y_W;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EW_A,
		ST_EW_B,
		ST_EW_C,
		ST_DECAY,
		ST_CHECK,
		ST_DIV,
		ST_WSEL,
		ST_CH_A,
		ST_CH_B,
		ST_CH_C,
		ST_OUT
	} state_t;

	state_t state_q;

	// run state
	logic signed [CW-1:0]     ewma_q;
	logic signed [CW-1:0]     chart_q;
	logic [31:0]              decay_q;
	logic [COUNT_WIDTH-1:0]   cnt_q;

	// result register
	logic                     out_valid_q;
	logic [SAMPLE_WIDTH-1:0]  stat_q;
	logic                     alarm_q;
	logic [RUN_W-1:0]         run_q;

	// working registers
	logic signed [CW-1:0]     z16_q;
	logic signed [PW-1:0]     acc_q;
	logic [31:0]              d_q;
	logic [CW-1:0]            mag_q;
	logic [31:0]              rem_q;
	logic [Y_W-1:0]           quo_q;
	logic                     big_q;
	logic [STEP_W-1:0]        step_q;
	logic [COEF_W-1:0]        lam_q;

	// shared multiplier
	logic signed [COEF_W-1:0] mul_a;
	logic signed [BW-1:0]     mul_b;
	logic signed [PW-1:0]     prod;

	logic [COEF_W-1:0]        om_x;
	logic [COEF_W-1:0]        inv_om;
	logic [COEF_W-1:0]        inv_lam;

	logic signed [SW-1:0]     mix_sum;
	logic signed [CW-1:0]     mix_rnd;
	logic signed [PW-1:0]     dec_sum;
	logic [31:0]              dec_rnd;
	logic [CW-1:0]            ewma_abs;

	logic [MW-1:0]            mag_x;
	logic                     mag_big;
	logic                     d_zero;
	logic [31:0]              rem_init;
	logic                     init_over;
	logic [32:0]              rem2;
	logic [33:0]              diff;
	logic                     fits;

	logic signed [CW:0]       r6;
	logic [SAMPLE_WIDTH:0]    stat_w;
	logic [SAMPLE_WIDTH-1:0]  stat_sat;
	logic signed [XW-1:0]     chart_x;
	logic signed [XW-1:0]     lim_x;
	logic signed [XW-1:0]     mag_w;
	logic                     alarm;
	logic [CXW-1:0]           cnt_x;
	logic [RUN_W-1:0]         run_sat;
	logic                     take;
	logic                     out_load;

	assign s_ready      = (state_q == ST_IDLE);
	assign take         = s_valid && s_ready;
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || m_ready);
	assign m_valid      = out_valid_q;
	assign m_statistic  = stat_q;
	assign m_alarm      = alarm_q;
	assign m_run_length = run_q;

	aec_mul #(
		.A_W (COEF_W),
		.B_W (BW)
	) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign om_x    = COEF_W'(cfg.smoothing);
	assign inv_om  = ONE_Q16 - om_x;
	assign inv_lam = ONE_Q16 - lam_q;

	// operand select per sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EW_A: begin
				mul_a = $signed(inv_om);
				mul_b = BW'(ewma_q);
			end
			ST_EW_B: begin
				mul_a = $signed(om_x);
				mul_b = BW'(z16_q);
			end
			ST_EW_C: begin
				mul_a = $signed(inv_om);
				mul_b = $signed(BW'(decay_q));
			end
			ST_CH_A: begin
				mul_a = $signed(inv_lam);
				mul_b = BW'(chart_q);
			end
			ST_CH_B: begin
				mul_a = $signed(lam_q);
				mul_b = BW'(z16_q);
			end
			default: begin
			end
		endcase
	end

	// blend of two products, rounded half up to Q.16
	assign mix_sum = SW'(acc_q) + SW'(prod) + SW'(32768);
	assign mix_rnd = mix_sum[16 +: CW];

	// decay power update, rounded
	assign dec_sum  = prod + PW'(32768);
	assign dec_rnd  = dec_sum[47:16];
	assign ewma_abs = ewma_q[CW-1] ? CW'(-ewma_q) : CW'(ewma_q);

	// bias correction checks and divider step
	assign mag_x     = MW'(mag_q);
	assign mag_big   = mag_x > MW'(STEP_BOUND[STEPS-1]);
	assign d_zero    = (d_q == '0);
	assign rem_init  = 32'({mag_x[Y_W-2:0], {PRE_SHIFT{1'b0}}});
	assign init_over = rem_init >= d_q;
	assign rem2      = {rem_q, 1'b0};
	assign diff      = {1'b0, rem2} - {2'b00, d_q};
	assign fits      = !diff[33];

	// statistic rounded to Q5.10 and saturated
	assign r6     = (CW+1)'(chart_q) + (CW+1)'(32);
	assign stat_w = r6[CW:6];
	always_comb begin
		if (stat_w[SAMPLE_WIDTH] != stat_w[SAMPLE_WIDTH-1]) begin
			stat_sat = {stat_w[SAMPLE_WIDTH], {(SAMPLE_WIDTH-1){~stat_w[SAMPLE_WIDTH]}}};
		end else begin
			stat_sat = stat_w[SAMPLE_WIDTH-1:0];
		end
	end

	// limit test
	assign chart_x = XW'(chart_q);
	assign lim_x   = $signed(XW'({cfg.limit, 6'b0}));
	assign mag_w   = (chart_x < 0) ? -chart_x : chart_x;
	assign alarm   = cfg.two_sided ? (mag_w > lim_x) : (chart_x > lim_x);

	// run length clipped to the result field
	assign cnt_x   = CXW'(cnt_q);
	assign run_sat = (cnt_x > CXW'({RUN_W{1'b1}})) ? {RUN_W{1'b1}} : cnt_x[RUN_W-1:0];

	// sequencer, run state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			stat_q      <= '0;
			alarm_q     <= 1'b0;
			run_q       <= '0;
			ewma_q      <= '0;
			chart_q     <= '0;
			decay_q     <= ONE_Q31;
			cnt_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_EW_A;
					end
				end
				ST_EW_A: begin
					state_q <= ST_EW_B;
				end
				ST_EW_B: begin
					state_q <= ST_EW_C;
				end
				ST_EW_C: begin
					ewma_q  <= mix_rnd;
					state_q <= ST_DECAY;
				end
				ST_DECAY: begin
					decay_q <= dec_rnd;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (mag_big || d_zero || init_over) begin
						state_q <= ST_WSEL;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_WSEL;
					end
				end
				ST_WSEL: begin
					state_q <= ST_CH_A;
				end
				ST_CH_A: begin
					state_q <= ST_CH_B;
				end
				ST_CH_B: begin
					state_q <= ST_CH_C;
				end
				ST_CH_C: begin
					chart_q <= mix_rnd;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						stat_q      <= stat_sat;
						alarm_q     <= alarm;
						run_q       <= run_sat;
						state_q     <= ST_IDLE;
						// restart the run after an alarm
						if (alarm) begin
							ewma_q  <= '0;
							chart_q <= '0;
							decay_q <= ONE_Q31;
							cnt_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					z16_q <= $signed({s_sample, 6'b0});
				end
			end
			ST_EW_B, ST_CH_B: begin
				acc_q <= prod;
			end
			ST_DECAY: begin
				d_q   <= ONE_Q31 - dec_rnd;
				mag_q <= ewma_abs;
			end
			ST_CHECK: begin
				big_q  <= mag_big || (!d_zero && init_over);
				quo_q  <= d_zero ? mag_x[Y_W-1:0] : '0;
				rem_q  <= rem_init;
				step_q <= STEP_W'(Y_W - 1);
			end
			ST_DIV: begin
				rem_q  <= fits ? diff[31:0] : rem2[31:0];
				quo_q  <= {quo_q[Y_W-2:0], fits};
				step_q <= step_q - 1'b1;
			end
			ST_WSEL: begin
				lam_q <= big_q ? ONE_Q16 : aec_weight(quo_q);
			end
			default: begin
			end
		endcase
	end

endmodule

/* design/adaptive_ewma_chart_top.sv */
// channel  | direction | handshake                  | payload
// s_*      | in        | s_tvalid / s_tready        | s_tdata: sample
// m_*      | out       | m_tvalid / m_tready        | m_tdata: statistic, alarm, run_length
// apb      | in        | psel, penable, pready      | paddr, pwdata, prdata
//
// one sample at a time through a shared multiplier and a restoring divider;
// the bias-correction divide takes 19 quotient steps and is skipped when the
// ewma is large against the divisor or smoothing is zero.
// reset restores the registers and clears the run state at once; no clearing pass.
// a finished result waits in the output register while the next sample is taken;
// the sequencer holds in its final step only if that register is still full.
module adaptive_ewma_chart_top
	import aec_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,     // sample
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [((SAMPLE_WIDTH+33+7)/8)*8-1:0] m_tdata,  // statistic, alarm, run_length
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int OUT_W = ((SAMPLE_WIDTH + 33 + 7) / 8) * 8;

	aec_cfg_t                cfg;
	logic [SAMPLE_WIDTH-1:0] statistic;
	logic                    alarm;
	logic [RUN_W-1:0]        run_length;

	aec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aec_core #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s_valid      (s_tvalid),
		.s_ready      (s_tready),
		.s_sample     (s_tdata[SAMPLE_WIDTH-1:0]),
		.m_valid      (m_tvalid),
		.m_ready      (m_tready),
		.m_statistic  (statistic),
		.m_alarm      (alarm),
		.m_run_length (run_length)
	);

	// result packing, statistic in the lowest bits
	assign m_tdata = OUT_W'({run_length, alarm, statistic});

`ifndef SYNTHESIS
	// one sample in flight: busy right after a transaction is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a sample is in work");

	// a result counts at least the sample that caused it
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (run_length != '0))
		else $error("result with zero run length");

	// a new result only comes out of a busy sequence
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a sample in work");
`endif

endmodule

/* bench/aec_chart_checker.sv */
module aec_chart_checker
	import aec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,     // sample
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [55:0]       m_tdata,     // statistic, alarm, run_length, zero pad
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                mismatch_count,
	output int                outstanding
);

	// one chart result, laid out as on m_tdata
	typedef struct packed {
		logic [31:0] run_length;
		logic        alarm;
		logic [15:0] statistic;
	} chart_result_t;

	chart_result_t expected_chart_q[$];

	// register copies
	logic [15:0] omega_q16;
	logic [14:0] limit_q10;
	logic        two_sided_test;

	// run state of the chart
	longint      ewma_q16;
	logic [63:0] decay_q31;
	longint      chart_q16;
	logic [31:0] run_count;

	// floor((v + 2^(s-1)) / 2^s)
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// weight from the bias-corrected ewma magnitude
	function automatic longint step_weight(input logic [63:0] mag, input logic [63:0] denom);
		logic [63:0] y;
		if (mag > 64'd229376) begin
			return 65536;
		end
		y = (denom == 64'd0) ? mag : (mag << 31) / denom;
		if (y == 64'd0) return 0;
		if (y <= 64'd16384) return 983;
		if (y <= 64'd49152) return 6554;
		if (y <= 64'd65536) return 13107;
		if (y <= 64'd98304) return 16384;
		if (y <= 64'd163840) return 32768;
		if (y <= 64'd229376) return 52429;
		return 65536;
	endfunction

	task automatic clear_run();
		ewma_q16 = 0;
		decay_q31 = 64'h8000_0000;
		chart_q16 = 0;
		run_count = '0;
	endtask

	// one sample through the chart: updates the run and gives the result
	task automatic advance_chart(input logic [15:0] raw, output chart_result_t res);
		longint z16, om, lam, stat, mag_w, lim;
		logic [63:0] mag, denom;
		logic alarm;
		z16 = longint'($signed(raw)) * 64;
		if (run_count != '1) begin
			run_count = run_count + 1;
		end
		om = longint'(omega_q16);
		ewma_q16 = round_shift(om * z16 + (65536 - om) * ewma_q16, 16);
		decay_q31 = (decay_q31 * (64'd65536 - 64'(omega_q16)) + 64'd32768) >> 16;
		denom = 64'h8000_0000 - decay_q31;
		mag = (ewma_q16 < 0) ? 64'(-ewma_q16) : 64'(ewma_q16);
		lam = step_weight(mag, denom);
		chart_q16 = round_shift(lam * z16 + (65536 - lam) * chart_q16, 16);
		lim = longint'(limit_q10) * 64;
		mag_w = (chart_q16 < 0) ? -chart_q16 : chart_q16;
		alarm = two_sided_test ? (mag_w > lim) : (chart_q16 > lim);
		stat = round_shift(chart_q16, 6);
		if (stat > 32767) stat = 32767;
		if (stat < -32768) stat = -32768;
		res.statistic = stat[15:0];
		res.alarm = alarm;
		res.run_length = run_count;
		if (alarm) begin
			clear_run();
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 40) begin
			$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		end
		mismatch_count++;
	endtask

	// watch config writes and both stream channels
	always @(posedge clk or negedge arst_n) begin
		chart_result_t got, want, res;
		if (!arst_n) begin
			omega_q16 = SMOOTHING_RST;
			limit_q10 = LIMIT_RST;
			two_sided_test = TWO_SIDED_RST;
			clear_run();
			expected_chart_q.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready) begin
				case (aec_reg_t'(paddr[ADDR_W-1:2]))
					REG_SMOOTHING: omega_q16 = pwdata[15:0];
					REG_LIMIT:     limit_q10 = pwdata[14:0];
					REG_TWO_SIDED: two_sided_test = pwdata[0];
					default: ;
				endcase
			end
			// result transaction
			if (m_tvalid && m_tready) begin
				got = chart_result_t'(m_tdata[48:0]);
				if (expected_chart_q.size() == 0) begin
					report_mismatch("unexpected result, statistic", $signed(got.statistic), 0);
				end else begin
					want = expected_chart_q.pop_front();
					if (got.statistic !== want.statistic)
						report_mismatch("statistic", $signed(got.statistic), $signed(want.statistic));
					if (got.alarm !== want.alarm)
						report_mismatch("alarm", got.alarm, want.alarm);
					if (got.run_length !== want.run_length)
						report_mismatch("run_length", got.run_length, want.run_length);
				end
			end
			// sample transaction
			if (s_tvalid && s_tready) begin
				advance_chart(s_tdata, res);
				expected_chart_q.push_back(res);
			end
			outstanding <= expected_chart_q.size();
		end
	end

endmodule

/* bench/tb_adaptive_ewma_chart_top.sv */
module tb_adaptive_ewma_chart_top;
	import aec_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;     // sample
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [55:0]       m_tdata;          // statistic, alarm, run_length, zero pad
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int mismatch_count;
	int outstanding;
	int tx_idle_pct = 26;
	int rx_idle_pct = 51;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_count = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	adaptive_ewma_chart_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	aec_chart_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_CYCLES) begin
				hold_done = 1'b1;
			end
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("adaptive_ewma_chart_top regression: fail");
			$finish;
		end
	end

	// offer one sample, with random idle cycles first
	task automatic send_sample(input logic [15:0] value);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= value;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// setup phase, then access phase, then idle
	task automatic apb_write(input aec_reg_t sel_reg, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({sel_reg, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_chart(input int omega, input int lim, input int two);
		apb_write(REG_SMOOTHING, DATA_W'(omega));
		apb_write(REG_LIMIT, DATA_W'(lim));
		apb_write(REG_TWO_SIDED, DATA_W'(two));
	endtask

	// wait until every result is back and the block has settled
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// process noise around a shifting mean, sometimes full-range outliers
	function automatic logic [15:0] noisy_sample(input int mean);
		int v;
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			return 16'($urandom);
		end else if (pick < 40) begin
			v = mean + int'($urandom_range(12288)) - 6144;
		end else begin
			v = mean + int'($urandom_range(4096)) - 2048;
		end
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	function automatic int pick_mean();
		case ($urandom_range(4))
			0: return 0;
			1: return 1024;
			2: return -1024;
			3: return 2048;
			default: return -3072;
		endcase
	endfunction

	logic [15:0] reset_cfg_samples [10] = '{
		16'h0000, 16'h0001, 16'hFFFF, 16'h0400, 16'hFC00,
		16'h5555, 16'hAAAA, 16'h0C00, 16'h7FFF, 16'h8000
	};

	initial begin
		int seg, i, mean;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: reset smoothing and limit, alarms both ways
		foreach (reset_cfg_samples[k]) send_sample(reset_cfg_samples[k]);
		wait_idle();

		// fastest smoothing, top limit: large ewma without alarm, then -32 alarms
		set_chart(65535, 32767, 1);
		send_sample(16'h7000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		wait_idle();

		// slowest smoothing, zero limit, upward test only
		set_chart(1, 0, 0);
		send_sample(16'hF000);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'h0000);
		wait_idle();

		// zero smoothing: no bias correction, chart never moves
		set_chart(0, 1024, 1);
		send_sample(16'h0400);
		send_sample(16'h0800);
		send_sample(16'h1000);

		// random segments, each under its own setting
		for (seg = 0; seg < 8; seg++) begin
			wait_idle();
			if (seg < 3) begin
				tx_idle_pct = 26;
				rx_idle_pct = 51;
			end else if (seg < 6) begin
				tx_idle_pct = 51;
				rx_idle_pct = 26;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (seg)
				0: set_chart($urandom_range(1, 65535), $urandom_range(1024, 8192), 1);
				1: set_chart(1, 0, 0);
				2: set_chart(65535, 32767, 1);
				3: set_chart(0, $urandom_range(0, 4096), 1);
				5: set_chart($urandom_range(1, 65535), $urandom_range(0, 8191), 0);
				default: set_chart($urandom_range(1, 65535), $urandom_range(0, 8191),
					$urandom_range(1));
			endcase
			mean = 0;
			for (i = 0; i < 50; i++) begin
				if (i % 10 == 0) mean = pick_mean();
				if (seg == 0 && i == 10) hold_req = 1'b1;
				send_sample(noisy_sample(mean));
			end
		end
		wait_idle();

		if (mismatch_count == 0) begin
			$display("adaptive_ewma_chart_top regression: pass");
		end else begin
			$display("adaptive_ewma_chart_top regression: fail");
		end
		$finish;
	end

endmodule
